@@ sv/tscs_pkg.sv @@
`default_nettype none
package tscs_pkg;
  localparam int unsigned SumBits = 18;
  localparam logic [1:0] AddrTargetSum = 2'b00;
endpackage
`default_nettype wire

@@ sv/three_sum_closest_search_top.sv @@
`default_nettype none
// Value items load while input is not stalled; a last item starts the sort and search
// once three or more values are held: an insertion sort that shifts larger values up,
// then a two-pointer search per distinct first element, on one read and one write port.
// A dataset of fewer than three values gives a too-few result and is not searched.
// Input is stalled from the last item until the search ends; items load while a result waits.
// Reset clears control state and the target register; the value memory is not cleared.
module three_sum_closest_search_top #(
  parameter int unsigned MAX_COUNT = 256,
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [1:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic signed [VALUE_BITS-1:0] value_i,
  input  wire logic                  last_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [tscs_pkg::SumBits-1:0] closest_sum_o,
  output logic                       too_few_o,
  output logic                       overflowed_o
);
  import tscs_pkg::*;

  localparam int unsigned AddrBits = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int unsigned CntBits = $clog2(MAX_COUNT + 1);

  logic signed [SumBits-1:0] target_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic ovf_q, ovf_d, pend_q, pend_d, penf_q, penf_d;
  logic busy, done, acc, ld, slot_free, start;
  logic signed [SumBits-1:0] esum;
  logic ov_q, ov_d, few_q, few_d, res_ovf_q, res_ovf_d;
  logic signed [SumBits-1:0] rsum_q, rsum_d;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrTargetSum) ? 32'(target_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) target_q <= '0;
    else if (psel && penable && pwrite && pready && paddr == AddrTargetSum)
      target_q <= pwdata[SumBits-1:0];
  end

  // Hold off input while a finished dataset waits for the search or is being searched.
  assign in_stall_o = busy || pend_q;
  assign acc = in_valid_i && !in_stall_o;
  assign ld = acc && (cnt_q < CntBits'(MAX_COUNT));
  assign slot_free = !ov_q || !out_stall_i;
  assign start = pend_q && !penf_q && !busy && slot_free;

  tscs_engine #(.MaxCount(MAX_COUNT), .ValueBits(VALUE_BITS),
                .AddrBits(AddrBits), .CntBits(CntBits)) u_engine (
    .clk_i, .rst_ni,
    .start_i(start),
    .count_i(cnt_q), .target_i(target_q),
    .busy_o(busy), .done_o(done), .sum_o(esum),
    .ld_we_i(ld), .ld_addr_i(cnt_q[AddrBits-1:0]), .ld_data_i(value_i)
  );

  always_comb begin
    cnt_d = cnt_q; ovf_d = ovf_q; pend_d = pend_q; penf_d = penf_q;
    ov_d = ov_q; few_d = few_q; res_ovf_d = res_ovf_q; rsum_d = rsum_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (acc) begin
      if (ld) cnt_d = cnt_q + CntBits'(1);
      else ovf_d = 1'b1;
      if (last_i) begin
        pend_d = 1'b1;
        penf_d = (cnt_d < CntBits'(3));
      end
    end
    if (pend_q && penf_q && slot_free) begin
      ov_d = 1'b1; rsum_d = '0; few_d = 1'b1; res_ovf_d = ovf_q;
      pend_d = 1'b0; penf_d = 1'b0; cnt_d = '0; ovf_d = 1'b0;
    end else if (start) begin
      pend_d = 1'b0;
    end else if (done) begin
      ov_d = 1'b1; rsum_d = esum; few_d = 1'b0; res_ovf_d = ovf_q;
      cnt_d = '0; ovf_d = 1'b0;
    end
  end

  // The engine only runs when the output slot is free, so done never collides.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; ovf_q <= 1'b0; pend_q <= 1'b0; penf_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; ovf_q <= ovf_d; pend_q <= pend_d; penf_q <= penf_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    few_q <= few_d; res_ovf_q <= res_ovf_d; rsum_q <= rsum_d;
  end

  assign out_valid_o = ov_q;
  assign closest_sum_o = rsum_q;
  assign too_few_o = few_q;
  assign overflowed_o = res_ovf_q;
endmodule
`default_nettype wire

@@ sv/tscs_store.sv @@
`default_nettype none
module tscs_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 16,
  parameter int unsigned AddrBits = 8
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [Width-1:0]    rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ sv/tscs_engine.sv @@
`default_nettype none
module tscs_engine #(
  parameter int unsigned MaxCount = 256,
  parameter int unsigned ValueBits = 16,
  parameter int unsigned AddrBits = 8,
  parameter int unsigned CntBits = 9
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [CntBits-1:0]          count_i,
  input  wire logic signed [tscs_pkg::SumBits-1:0] target_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic signed [tscs_pkg::SumBits-1:0] sum_o,
  input  wire logic                        ld_we_i,
  input  wire logic [AddrBits-1:0]         ld_addr_i,
  input  wire logic [ValueBits-1:0]        ld_data_i
);
  import tscs_pkg::*;

  // Wide enough for any triple sum and for the 18-bit target.
  localparam int unsigned WB = (ValueBits + 4 > SumBits + 2) ? ValueBits + 4 : SumBits + 2;
  localparam logic [3:0] SIdle = 4'd0, SSortRd = 4'd1, SSortCmp = 4'd2,
                         SFirst = 4'd3, SRdI = 4'd4, SGetI = 4'd5,
                         SRdL = 4'd6, SGetL = 4'd7, SRdR = 4'd8,
                         SGetR = 4'd9, SRdM = 4'd10, SGetM = 4'd11,
                         SEval = 4'd12, SDone = 4'd13, SSortWr = 4'd14;

  logic [3:0] st_q, st_d;
  logic [CntBits-1:0] i_q, i_d, j_q, j_d, l_q, l_d, r_q, r_d, m_q, m_d;
  logic signed [ValueBits-1:0] key_q, key_d, ai_q, ai_d, al_q, al_d, ar_q, ar_d, am_q, am_d;
  logic signed [ValueBits-1:0] prev_q, prev_d;
  logic have_prev_q, have_prev_d;
  logic signed [WB-1:0] best_q, best_d, cand;
  logic [1:0] fcnt_q, fcnt_d;
  logic we;
  logic [AddrBits-1:0] waddr, raddr;
  logic [ValueBits-1:0] wdata, rdata;
  logic signed [WB-1:0] tgt, lo, hi, cur;
  logic [CntBits-1:0] span;
  logic use_mid;

  tscs_store #(.Depth(MaxCount), .Width(ValueBits), .AddrBits(AddrBits)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [WB-1:0] absdiff(logic signed [WB-1:0] a, logic signed [WB-1:0] b);
    return (a > b) ? WB'(a - b) : WB'(b - a);
  endfunction

  function automatic logic better(logic signed [WB-1:0] c, logic signed [WB-1:0] b,
                                  logic signed [WB-1:0] t);
    logic [WB:0] dc, db;
    dc = {1'b0, absdiff(c, t)};
    db = {1'b0, absdiff(b, t)};
    return dc < db;
  endfunction

  assign tgt = WB'(target_i);
  assign lo = WB'(ai_q) + WB'(al_q) + WB'(am_q);
  assign hi = WB'(ai_q) + WB'(am_q) + WB'(ar_q);
  assign cur = WB'(ai_q) + WB'(al_q) + WB'(ar_q);
  assign span = r_q - l_q;
  assign use_mid = span >= CntBits'(2);

  always_comb begin
    st_d = st_q; i_d = i_q; j_d = j_q; l_d = l_q; r_d = r_q; m_d = m_q;
    key_d = key_q; ai_d = ai_q; al_d = al_q; ar_d = ar_q; am_d = am_q;
    prev_d = prev_q; have_prev_d = have_prev_q; best_d = best_q; fcnt_d = fcnt_q;
    we = ld_we_i; waddr = ld_addr_i; wdata = ld_data_i; raddr = '0;
    done_o = 1'b0; cand = cur;
    case (st_q)
      SIdle: if (start_i) begin
        i_d = CntBits'(1);
        st_d = SSortRd;
      end
      // Insertion sort: read the key, then shift larger entries up one by one.
      SSortRd: begin
        if (i_q >= count_i) begin
          st_d = SFirst; fcnt_d = '0; best_d = '0; raddr = '0;
        end else begin
          raddr = i_q[AddrBits-1:0]; j_d = i_q; st_d = SSortCmp; fcnt_d = '0;
        end
      end
      SSortCmp: begin
        if (fcnt_q == 2'd0) begin
          key_d = rdata; fcnt_d = 2'd1;
        end
        raddr = AddrBits'(j_d - CntBits'(1));
        if (j_q == '0) begin
          st_d = SSortWr;
        end else begin
          st_d = SSortWr; fcnt_d = 2'd2;
        end
      end
      SSortWr: begin
        if (fcnt_q == 2'd2 && $signed(rdata) > key_q) begin
          we = 1'b1; waddr = j_q[AddrBits-1:0]; wdata = rdata;
          j_d = j_q - CntBits'(1); st_d = SSortCmp; fcnt_d = 2'd1;
        end else begin
          we = 1'b1; waddr = j_q[AddrBits-1:0]; wdata = key_q;
          i_d = i_q + CntBits'(1); st_d = SSortRd;
        end
      end
      // Sum of the three smallest values seeds the result.
      SFirst: begin
        raddr = AddrBits'(fcnt_q + 2'd1);
        if (fcnt_q == 2'd0) best_d = WB'($signed(rdata));
        else best_d = best_q + WB'($signed(rdata));
        fcnt_d = fcnt_q + 2'd1;
        if (fcnt_q == 2'd2) begin
          i_d = '0; have_prev_d = 1'b0; st_d = SRdI;
        end
      end
      SRdI: begin
        if (i_q + CntBits'(2) >= count_i) st_d = SDone;
        else begin raddr = i_q[AddrBits-1:0]; st_d = SGetI; end
      end
      SGetI: begin
        if (have_prev_q && $signed(rdata) == prev_q) begin
          i_d = i_q + CntBits'(1); st_d = SRdI;
        end else begin
          ai_d = rdata; prev_d = rdata; have_prev_d = 1'b1;
          l_d = i_q + CntBits'(1); r_d = count_i - CntBits'(1); st_d = SRdL;
        end
      end
      SRdL: begin
        if (l_q >= r_q) begin i_d = i_q + CntBits'(1); st_d = SRdI; end
        else begin raddr = l_q[AddrBits-1:0]; st_d = SGetL; end
      end
      SGetL: begin al_d = rdata; raddr = r_q[AddrBits-1:0]; st_d = SGetR; end
      SGetR: begin
        ar_d = rdata;
        m_d = l_q + (span >> 1);
        raddr = AddrBits'(l_q + (span >> 1));
        st_d = SGetM;
      end
      SGetM: begin am_d = rdata; st_d = SEval; end
      SEval: begin
        if (use_mid && lo > tgt) begin
          cand = lo; r_d = m_q - CntBits'(1);
        end else if (use_mid && hi < tgt) begin
          cand = hi; l_d = m_q + CntBits'(1);
        end else begin
          cand = cur;
          if (cur < tgt) l_d = l_q + CntBits'(1);
          else r_d = r_q - CntBits'(1);
        end
        if (better(cand, best_q, tgt)) best_d = cand;
        st_d = SRdL;
      end
      SDone: begin done_o = 1'b1; st_d = SIdle; end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; l_q <= l_d; r_q <= r_d; m_q <= m_d;
    key_q <= key_d; ai_q <= ai_d; al_q <= al_d; ar_q <= ar_d; am_q <= am_d;
    prev_q <= prev_d; have_prev_q <= have_prev_d; best_q <= best_d; fcnt_q <= fcnt_d;
  end

  assign busy_o = st_q != SIdle;
  assign sum_o = best_q[SumBits-1:0];
endmodule
`default_nettype wire
